/* rtl/mcl_pkg.sv */
// Package for the magnetometer calibration and low-pass block.
// Holds widths, register indexes, reset values, the sequencer states and the
// lane control struct. No dependencies.
package mcl_pkg;

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned DIFF_W     = 17;
	localparam int unsigned COEF_W     = 16;
	localparam int unsigned GAIN_W     = 17;
	localparam int unsigned STATE_W    = 32;
	localparam int unsigned REG_W      = 48;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_ADDR_W = 6;
	localparam int unsigned AXES       = 3;
	localparam int unsigned S_DATA_W   = AXES * SAMPLE_W;
	localparam int unsigned M_DATA_W   = 2 * AXES * SAMPLE_W;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

	localparam logic [REG_W-1:0] OFFSETS_RST = 48'h0;
	localparam logic [REG_W-1:0] COEF_X_RST  = 48'h0000_0000_4000;
	localparam logic [REG_W-1:0] COEF_Y_RST  = 48'h0000_4000_0000;
	localparam logic [REG_W-1:0] COEF_Z_RST  = 48'h4000_0000_0000;

	typedef enum logic [2:0] {
		REG_OFFSETS = 3'd0,
		REG_COEF_X  = 3'd1,
		REG_COEF_Y  = 3'd2,
		REG_COEF_Z  = 3'd3,
		REG_GAIN    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_ACC,
		ST_ROUND,
		ST_ERR,
		ST_FMUL,
		ST_UPD,
		ST_DONE
	} state_t;

	// Strobes from the sequencer to every lane.
	typedef struct packed {
		logic mul_en;
		logic acc_clr;
		logic acc_add;
		logic round_en;
		logic err_en;
		logic fmul_en;
		logic upd_en;
	} lane_ctl_t;

endpackage

/* rtl/mag_calibrate_lowpass.sv */
// Magnetometer hard/soft-iron calibration with a per-axis low-pass filter.
// A new sample is taken only in the idle state, after the last result has
// been loaded into the output stage. Each lane forms its three matrix
// products in turn on one multiplier and the filter product on another.
// Reset sets identity calibration, pass-through gain and zero filter state.
// Depends on mcl_pkg, mcl_lane and mcl_merge.
module mag_calibrate_lowpass (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input item: sample_x [15:0], sample_y [31:16], sample_z [47:32]
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [mcl_pkg::S_DATA_W-1:0]           s_tdata,
	// Result item: cal_x [15:0], cal_y [31:16], cal_z [47:32],
	// filt_x [63:48], filt_y [79:64], filt_z [95:80]
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [mcl_pkg::M_DATA_W-1:0]           m_tdata,
	// Configuration port; register i sits at byte address 8*i.
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [mcl_pkg::CFG_ADDR_W-1:0]         paddr,
	input  logic [mcl_pkg::CFG_DATA_W-1:0]         pwdata,
	output logic [mcl_pkg::CFG_DATA_W-1:0]         prdata,
	output logic                                   pready
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes land on the access cycle; reads are
	// combinational. Addresses past the last register read as zero and
	// ignore writes.
	// ------------------------------------------------------------------
	logic [mcl_pkg::REG_W-1:0]  offs_q;
	logic [mcl_pkg::REG_W-1:0]  coef_q [mcl_pkg::AXES];
	logic [mcl_pkg::GAIN_W-1:0] gain_q;
	mcl_pkg::reg_idx_t          reg_idx;
	logic                       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = mcl_pkg::reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offs_q    <= mcl_pkg::OFFSETS_RST;
			coef_q[0] <= mcl_pkg::COEF_X_RST;
			coef_q[1] <= mcl_pkg::COEF_Y_RST;
			coef_q[2] <= mcl_pkg::COEF_Z_RST;
			gain_q    <= mcl_pkg::GAIN_ONE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				mcl_pkg::REG_OFFSETS: offs_q    <= pwdata[mcl_pkg::REG_W-1:0];
				mcl_pkg::REG_COEF_X:  coef_q[0] <= pwdata[mcl_pkg::REG_W-1:0];
				mcl_pkg::REG_COEF_Y:  coef_q[1] <= pwdata[mcl_pkg::REG_W-1:0];
				mcl_pkg::REG_COEF_Z:  coef_q[2] <= pwdata[mcl_pkg::REG_W-1:0];
				mcl_pkg::REG_GAIN:    gain_q    <= pwdata[mcl_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mcl_pkg::REG_OFFSETS: prdata = {16'h0000, offs_q};
			mcl_pkg::REG_COEF_X:  prdata = {16'h0000, coef_q[0]};
			mcl_pkg::REG_COEF_Y:  prdata = {16'h0000, coef_q[1]};
			mcl_pkg::REG_COEF_Z:  prdata = {16'h0000, coef_q[2]};
			mcl_pkg::REG_GAIN:    prdata = {47'h0, gain_q};
			default:              prdata = '0;
		endcase
	end

	// A gain above one behaves exactly like one: the sample passes through.
	logic [mcl_pkg::GAIN_W-1:0] gain_k;
	assign gain_k = (gain_q > mcl_pkg::GAIN_ONE) ? mcl_pkg::GAIN_ONE : gain_q;

	// ------------------------------------------------------------------
	// Input capture. The offset subtraction is done on accept and kept as
	// exact 17-bit differences, one per input axis.
	// ------------------------------------------------------------------
	logic signed [mcl_pkg::DIFF_W-1:0] diff_q [mcl_pkg::AXES];
	logic                              in_acc;

	assign in_acc = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < mcl_pkg::AXES; i++) begin
				diff_q[i] <= $signed({s_tdata[16*i+15], s_tdata[16*i +: 16]})
					- $signed({offs_q[16*i+15], offs_q[16*i +: 16]});
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer. In the MAC phase step_q walks the input axes; every lane
	// multiplies the same difference by its own column entry. The remaining
	// phases finish the accumulation, round and saturate, form the filter
	// error, multiply by the gain and update the state. The result is then
	// handed to the output stage as soon as it has room.
	// ------------------------------------------------------------------
	mcl_pkg::state_t    state_q, state_d;
	logic [1:0]         step_q, step_d;
	mcl_pkg::lane_ctl_t ctl;
	logic               load;
	logic               out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcl_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		ctl      = '0;
		load     = 1'b0;
		s_tready = 1'b0;
		unique case (state_q)
			mcl_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = mcl_pkg::ST_MAC;
					step_d  = '0;
				end
			end
			mcl_pkg::ST_MAC: begin
				ctl.mul_en  = 1'b1;
				ctl.acc_clr = (step_q == 2'd0);
				ctl.acc_add = (step_q != 2'd0);
				if (step_q == 2'(mcl_pkg::AXES - 1)) begin
					state_d = mcl_pkg::ST_ACC;
					step_d  = '0;
				end else begin
					step_d = step_q + 2'd1;
				end
			end
			mcl_pkg::ST_ACC: begin
				ctl.acc_add = 1'b1;
				state_d     = mcl_pkg::ST_ROUND;
			end
			mcl_pkg::ST_ROUND: begin
				ctl.round_en = 1'b1;
				state_d      = mcl_pkg::ST_ERR;
			end
			mcl_pkg::ST_ERR: begin
				ctl.err_en = 1'b1;
				state_d    = mcl_pkg::ST_FMUL;
			end
			mcl_pkg::ST_FMUL: begin
				ctl.fmul_en = 1'b1;
				state_d     = mcl_pkg::ST_UPD;
			end
			mcl_pkg::ST_UPD: begin
				ctl.upd_en = 1'b1;
				state_d    = mcl_pkg::ST_DONE;
			end
			mcl_pkg::ST_DONE: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = mcl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mcl_pkg::ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Lanes: one per output axis, all driven by the same strobes.
	// ------------------------------------------------------------------
	logic signed [mcl_pkg::DIFF_W-1:0]   diff_sel;
	logic [mcl_pkg::REG_W-1:0]           col_sel;
	logic signed [mcl_pkg::SAMPLE_W-1:0] cal_w  [mcl_pkg::AXES];
	logic signed [mcl_pkg::SAMPLE_W-1:0] filt_w [mcl_pkg::AXES];

	assign diff_sel = diff_q[step_q];
	assign col_sel  = coef_q[step_q];

	for (genvar j = 0; j < mcl_pkg::AXES; j++) begin : g_lane
		mcl_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.coef   ($signed(col_sel[16*j +: 16])),
			.diff   (diff_sel),
			.gain   (gain_k),
			.cal    (cal_w[j]),
			.filt   (filt_w[j])
		);
	end

	mcl_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.cal      (cal_w),
		.filt     (filt_w),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// An accepted item always starts the product walk at the first axis.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == mcl_pkg::ST_MAC) && (step_q == 2'd0))
		else $error("accepted item did not start the MAC phase");

	// The output stage is only loaded when it can take a result.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!m_tvalid || m_tready))
		else $error("result loaded over an untaken item");

	// With zero gain the filter state must not move.
	a_zero_gain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.upd_en && (gain_k == '0)) |=>
			($stable(filt_w[0]) && $stable(filt_w[1]) && $stable(filt_w[2])))
		else $error("filter state moved with zero gain");

	// The step counter never leaves the axis range.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcl_pkg::ST_MAC) |-> (step_q != 2'd3))
		else $error("MAC step out of range");

endmodule

/* rtl/mcl_lane.sv */
// One output axis: a shared multiplier computes the three matrix products,
// then the rounding, saturation and low-pass update of that axis.
// Depends on mcl_pkg.
module mcl_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mcl_pkg::lane_ctl_t                ctl,
	input  logic signed [mcl_pkg::COEF_W-1:0] coef,
	input  logic signed [mcl_pkg::DIFF_W-1:0] diff,
	input  logic [mcl_pkg::GAIN_W-1:0]        gain,
	output logic signed [mcl_pkg::SAMPLE_W-1:0] cal,
	output logic signed [mcl_pkg::SAMPLE_W-1:0] filt
);

	logic signed [32:0] prod_q;
	logic signed [34:0] acc_q;
	logic signed [34:0] rnd_sum;
	logic signed [20:0] rnd;
	logic signed [15:0] sat;
	logic signed [15:0] cal_q;
	logic signed [32:0] err_q;
	logic signed [50:0] fprod_q;
	logic signed [50:0] fsum;
	logic signed [31:0] st_q;

	// Divide by 2^14 with ties toward plus infinity, then clamp to 16 bits.
	assign rnd_sum = acc_q + 35'sd8192;
	assign rnd     = rnd_sum[34:14];

	always_comb begin
		if (rnd > 21'sd32767) begin
			sat = 16'sh7fff;
		end else if (rnd < -21'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = rnd[15:0];
		end
	end

	assign fsum = fprod_q + 51'sd32768;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= coef * diff;
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + 35'(prod_q);
		end
		if (ctl.round_en) begin
			cal_q <= sat;
		end
		if (ctl.err_en) begin
			err_q <= $signed({cal_q[15], cal_q, 16'h0000}) - $signed({st_q[31], st_q});
		end
		if (ctl.fmul_en) begin
			fprod_q <= err_q * $signed({1'b0, gain});
		end
	end

	// The updated state always lies between the old state and the target,
	// so the low 32 bits of the step are enough.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (ctl.upd_en) begin
			st_q <= st_q + fsum[47:16];
		end
	end

	assign cal  = cal_q;
	assign filt = st_q[31:16];

endmodule

/* rtl/mcl_merge.sv */
// Output stage: gathers the three lanes into one result item and holds it
// until the downstream side takes it. Depends on mcl_pkg.
module mcl_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic signed [mcl_pkg::SAMPLE_W-1:0] cal  [mcl_pkg::AXES],
	input  logic signed [mcl_pkg::SAMPLE_W-1:0] filt [mcl_pkg::AXES],
	output logic                                out_free,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mcl_pkg::M_DATA_W-1:0]        m_tdata
);

	logic                         valid_q;
	logic [mcl_pkg::M_DATA_W-1:0] data_q;

	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {filt[2], filt[1], filt[0], cal[2], cal[1], cal[0]};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

/* sim/mag_calibrate_lowpass_test.sv */
// Self-checking testbench for the magnetometer calibration and low-pass block.
// Drives samples and register writes, predicts every result item in place.
// Depends on mcl_pkg and mag_calibrate_lowpass.
module mag_calibrate_lowpass_test;

	// The address map has eight slots of eight bytes; slots above the gain
	// register hold nothing, and writes to them must change nothing.
	localparam logic [2:0] SLOT_LAST = 3'd7;
	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned DRAIN_CYCLES = 30;
	localparam int unsigned PHASES = 12;
	localparam int unsigned PHASE_ITEMS = 150;
	localparam int unsigned MAX_GAP = 14;

	// Input item as it lies on s_tdata: sample_x in the lowest bits.
	typedef struct packed {
		logic signed [mcl_pkg::SAMPLE_W-1:0] sample_z;
		logic signed [mcl_pkg::SAMPLE_W-1:0] sample_y;
		logic signed [mcl_pkg::SAMPLE_W-1:0] sample_x;
	} mag_sample_t;

	// Result item as it lies on m_tdata: cal_x in the lowest bits.
	typedef struct packed {
		logic signed [mcl_pkg::SAMPLE_W-1:0] filt_z;
		logic signed [mcl_pkg::SAMPLE_W-1:0] filt_y;
		logic signed [mcl_pkg::SAMPLE_W-1:0] filt_x;
		logic signed [mcl_pkg::SAMPLE_W-1:0] cal_z;
		logic signed [mcl_pkg::SAMPLE_W-1:0] cal_y;
		logic signed [mcl_pkg::SAMPLE_W-1:0] cal_x;
	} mag_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [mcl_pkg::S_DATA_W-1:0]     s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [mcl_pkg::M_DATA_W-1:0]     m_tdata;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [mcl_pkg::CFG_ADDR_W-1:0]   paddr = '0;
	logic [mcl_pkg::CFG_DATA_W-1:0]   pwdata = '0;
	logic [mcl_pkg::CFG_DATA_W-1:0]   prdata;
	logic                             pready;

	// Our own copy of the registers and of the filter state.
	logic [mcl_pkg::REG_W-1:0]          offsets_mirror;
	logic [mcl_pkg::REG_W-1:0]          coef_mirror [mcl_pkg::AXES];
	logic [mcl_pkg::GAIN_W-1:0]         gain_mirror;
	logic signed [mcl_pkg::STATE_W-1:0] smooth_mirror [mcl_pkg::AXES];

	// Result items predicted at input accept, oldest first.
	mag_result_t calibrated_due [$];
	string       result_fields [6] = '{"cal_x", "cal_y", "cal_z",
		"filt_x", "filt_y", "filt_z"};

	int unsigned failures = 0;
	int unsigned idle_cycles = 0;
	// When set, neither side inserts gaps; used for back-to-back stretches.
	bit          steady = 1'b0;

	mag_calibrate_lowpass dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// Packs three signed 16-bit values, the first one in the lowest bits.
	function automatic logic [mcl_pkg::REG_W-1:0] pack_axes(input int lo, input int mid,
		input int hi);
		logic [mcl_pkg::REG_W-1:0] packed_val;
		packed_val[15:0]  = lo[15:0];
		packed_val[31:16] = mid[15:0];
		packed_val[47:32] = hi[15:0];
		return packed_val;
	endfunction

	// Offset subtraction, soft-iron matrix, round and saturate, then one
	// low-pass step per axis. The filter state is advanced as a side effect,
	// so this is called exactly once per accepted input item.
	function automatic mag_result_t calibrate_and_smooth(input mag_sample_t smp);
		longint                       diff [mcl_pkg::AXES];
		longint                       acc;
		longint                       cal;
		longint                       err;
		longint                       st;
		longint                       k;
		logic [mcl_pkg::S_DATA_W-1:0] raw;
		logic [mcl_pkg::M_DATA_W-1:0] flat;
		int                           i;
		int                           j;
		raw = smp;
		// A gain above one acts as exactly one, so the sample passes through.
		k = (gain_mirror > mcl_pkg::GAIN_ONE) ? longint'(mcl_pkg::GAIN_ONE)
			: longint'(gain_mirror);
		for (i = 0; i < mcl_pkg::AXES; i++) begin
			diff[i] = longint'($signed(raw[16*i +: 16]))
				- longint'($signed(offsets_mirror[16*i +: 16]));
		end
		for (j = 0; j < mcl_pkg::AXES; j++) begin
			acc = 0;
			for (i = 0; i < mcl_pkg::AXES; i++) begin
				acc += longint'($signed(coef_mirror[i][16*j +: 16])) * diff[i];
			end
			// Round half toward plus infinity, then clamp to 16 bits.
			cal = (acc + 8192) >>> 14;
			if (cal > 32767) begin
				cal = 32767;
			end else if (cal < -32768) begin
				cal = -32768;
			end
			st = longint'(smooth_mirror[j]);
			err = cal * 65536 - st;
			st = st + ((k * err + 32768) >>> 16);
			smooth_mirror[j] = st[31:0];
			flat[16*j +: 16] = cal[15:0];
			flat[48 + 16*j +: 16] = st[31:16];
		end
		return mag_result_t'(flat);
	endfunction

	// Value a register read should return: the stored low bits, zero above.
	function automatic logic [mcl_pkg::CFG_DATA_W-1:0] register_value(input logic [2:0] idx);
		case (idx)
			mcl_pkg::REG_OFFSETS: return {16'h0, offsets_mirror};
			mcl_pkg::REG_COEF_X:  return {16'h0, coef_mirror[0]};
			mcl_pkg::REG_COEF_Y:  return {16'h0, coef_mirror[1]};
			mcl_pkg::REG_COEF_Z:  return {16'h0, coef_mirror[2]};
			mcl_pkg::REG_GAIN:    return {47'h0, gain_mirror};
			default:              return '0;
		endcase
	endfunction

	// Reads a register through the config port and compares it with the copy.
	task automatic cfg_read_check(input logic [2:0] idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 3'b000};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== register_value(idx)) begin
			$error("prdata of register %0d: expected %h, got %h",
				idx, register_value(idx), prdata);
			failures++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Setup phase, access phase, then psel drops so that the next transfer never
	// drives psel twice in one step; writes to real registers are read back.
	task automatic cfg_write(input logic [2:0] idx,
		input logic [mcl_pkg::CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			mcl_pkg::REG_OFFSETS: offsets_mirror = value[mcl_pkg::REG_W-1:0];
			mcl_pkg::REG_COEF_X:  coef_mirror[0] = value[mcl_pkg::REG_W-1:0];
			mcl_pkg::REG_COEF_Y:  coef_mirror[1] = value[mcl_pkg::REG_W-1:0];
			mcl_pkg::REG_COEF_Z:  coef_mirror[2] = value[mcl_pkg::REG_W-1:0];
			mcl_pkg::REG_GAIN:    gain_mirror = value[mcl_pkg::GAIN_W-1:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx <= mcl_pkg::REG_GAIN) begin
			cfg_read_check(idx);
		end
	endtask

	// Offers one sample after a random gap and predicts its result on accept.
	task automatic send_sample(input mag_sample_t smp);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		do @(posedge clk); while (!s_tready);
		calibrated_due.push_back(calibrate_and_smooth(smp));
	endtask

	// Stops offering samples and waits for every predicted result to arrive,
	// which leaves the block idle for register writes.
	task automatic settle;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (calibrated_due.size() != 0);
	endtask

	// Reset values: identity matrix, zero offsets, pass-through gain, so every
	// result item repeats the sample in both halves.
	task automatic test_identity_defaults;
		int i;
		for (i = 0; i <= mcl_pkg::REG_GAIN; i++) begin
			cfg_read_check(3'(i));
		end
		send_sample(mag_sample_t'(pack_axes(0, 0, 0)));
		send_sample(mag_sample_t'(pack_axes(32767, 32767, 32767)));
		send_sample(mag_sample_t'(pack_axes(-32768, -32768, -32768)));
		send_sample(mag_sample_t'(pack_axes(1, -1, 12345)));
		send_sample(mag_sample_t'(pack_axes(-32768, 32767, 0)));
	endtask

	// Largest differences against the largest coefficients of both signs,
	// so the sums saturate both ways. The offset write also carries junk in
	// bits above 47, which the register must drop.
	task automatic test_matrix_extremes;
		settle();
		cfg_write(mcl_pkg::REG_OFFSETS, {16'hABCD, pack_axes(-32768, 32767, 0)});
		cfg_write(mcl_pkg::REG_COEF_X, {16'hFFFF, pack_axes(32767, -32768, -32768)});
		cfg_write(mcl_pkg::REG_COEF_Y, {16'h8001, pack_axes(32767, -32768, 32767)});
		cfg_write(mcl_pkg::REG_COEF_Z, {16'h0000, pack_axes(32767, 32767, -32768)});
		send_sample(mag_sample_t'(pack_axes(32767, -32768, 32767)));
		send_sample(mag_sample_t'(pack_axes(-32768, 32767, -32768)));
		send_sample(mag_sample_t'(pack_axes(0, 0, 0)));
	endtask

	// With weights of plus and minus one LSB, x lands exactly on half steps:
	// ties must round toward plus infinity on both signs.
	task automatic test_rounding_ties;
		settle();
		cfg_write(mcl_pkg::REG_OFFSETS, '0);
		cfg_write(mcl_pkg::REG_COEF_X, {16'h0000, pack_axes(1, 0, -1)});
		cfg_write(mcl_pkg::REG_COEF_Y, '0);
		cfg_write(mcl_pkg::REG_COEF_Z, '0);
		send_sample(mag_sample_t'(pack_axes(8192, 5, -5)));
		send_sample(mag_sample_t'(pack_axes(-8192, 0, 0)));
		send_sample(mag_sample_t'(pack_axes(24576, 0, 0)));
		send_sample(mag_sample_t'(pack_axes(8191, 0, 0)));
	endtask

	// Gain zero freezes the state, gain one LSB barely moves it, a gain
	// above one acts as pass-through, and a wide write keeps only 17 bits.
	task automatic test_gain_edges;
		settle();
		cfg_write(mcl_pkg::REG_COEF_X, {16'h0000, mcl_pkg::COEF_X_RST});
		cfg_write(mcl_pkg::REG_COEF_Y, {16'h0000, mcl_pkg::COEF_Y_RST});
		cfg_write(mcl_pkg::REG_COEF_Z, {16'h0000, mcl_pkg::COEF_Z_RST});
		cfg_write(mcl_pkg::REG_GAIN, '0);
		send_sample(mag_sample_t'(pack_axes(1000, -1000, 32767)));
		send_sample(mag_sample_t'(pack_axes(-32768, 32767, -32768)));
		send_sample(mag_sample_t'(pack_axes(7, 7, 7)));
		settle();
		cfg_write(mcl_pkg::REG_GAIN, 64'd1);
		send_sample(mag_sample_t'(pack_axes(32767, -32768, 32767)));
		send_sample(mag_sample_t'(pack_axes(-32768, 32767, -32768)));
		settle();
		cfg_write(mcl_pkg::REG_GAIN, 64'h1_FFFF);
		send_sample(mag_sample_t'(pack_axes(-32768, 32767, 12)));
		send_sample(mag_sample_t'(pack_axes(32767, -32768, -12)));
		settle();
		// Low 17 bits of this word are half gain.
		cfg_write(mcl_pkg::REG_GAIN, 64'hFFFF_FFFF_FFFE_8000);
		send_sample(mag_sample_t'(pack_axes(32767, 32767, 32767)));
		send_sample(mag_sample_t'(pack_axes(32767, -32768, 0)));
		send_sample(mag_sample_t'(pack_axes(-32768, -32768, -32768)));
	endtask

	// Writes to the empty slots must leave every real register unchanged.
	task automatic test_unknown_slots;
		int i;
		settle();
		for (i = mcl_pkg::REG_GAIN + 1; i <= SLOT_LAST; i++) begin
			cfg_write(3'(i), {$urandom, $urandom});
		end
		for (i = 0; i <= mcl_pkg::REG_GAIN; i++) begin
			cfg_read_check(3'(i));
		end
		send_sample(mag_sample_t'(pack_axes(-123, 4567, -8910)));
		send_sample(mag_sample_t'(pack_axes(32000, -32000, 1)));
	endtask

	// Phases with fresh random settings and random samples. Coefficients are
	// either fully random, which saturates often, or a perturbed identity,
	// which keeps most results in range. Some phases stop halfway until the
	// block has delivered everything.
	task automatic test_random_phases;
		int unsigned                    p;
		int unsigned                    n;
		int                             i;
		int                             j;
		int                             v;
		logic [mcl_pkg::REG_W-1:0]      coef;
		logic [mcl_pkg::S_DATA_W-1:0]   raw;
		logic [mcl_pkg::CFG_DATA_W-1:0] gain_word;
		for (p = 0; p < PHASES; p++) begin
			settle();
			if ($urandom_range(0, 1)) begin
				cfg_write(mcl_pkg::REG_OFFSETS, {$urandom, $urandom});
			end else begin
				cfg_write(mcl_pkg::REG_OFFSETS, {16'h0000,
					pack_axes($urandom_range(0, 4095) - 2048,
					$urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048)});
			end
			for (i = 0; i < mcl_pkg::AXES; i++) begin
				if ($urandom_range(0, 2) == 0) begin
					coef = mcl_pkg::REG_W'({$urandom, $urandom});
				end else begin
					for (j = 0; j < mcl_pkg::AXES; j++) begin
						v = ((i == j) ? 16384 : 0) + $urandom_range(0, 4095) - 2048;
						coef[16*j +: 16] = v[15:0];
					end
				end
				cfg_write(3'(mcl_pkg::REG_COEF_X + i), {16'($urandom), coef});
			end
			case ($urandom_range(0, 5))
				0: gain_word = '0;
				1: gain_word = mcl_pkg::CFG_DATA_W'(mcl_pkg::GAIN_ONE);
				2: gain_word = mcl_pkg::CFG_DATA_W'($urandom_range(0, mcl_pkg::GAIN_ONE));
				3: gain_word = mcl_pkg::CFG_DATA_W'($urandom_range(mcl_pkg::GAIN_ONE + 1,
					17'h1_FFFF));
				4: gain_word = mcl_pkg::CFG_DATA_W'($urandom_range(1, 4096));
				default: gain_word = {$urandom, $urandom};
			endcase
			cfg_write(mcl_pkg::REG_GAIN, gain_word);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0) begin
					steady = ($urandom_range(0, 3) == 0);
				end
				if (p % 3 == 1 && n == PHASE_ITEMS / 2) begin
					settle();
				end
				if ($urandom_range(0, 3) == 0) begin
					raw = pack_axes($urandom_range(0, 511) - 256,
						$urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256);
				end else begin
					raw = mcl_pkg::S_DATA_W'({$urandom, $urandom});
				end
				send_sample(mag_sample_t'(raw));
			end
		end
		steady = 1'b0;
	endtask

	// Result side: stalls a random number of cycles per item, then holds
	// m_tready high until an item arrives and checks it against the oldest
	// prediction.
	initial begin : result_sink
		int unsigned                  stall;
		int                           f;
		logic [mcl_pkg::M_DATA_W-1:0] got;
		logic [mcl_pkg::M_DATA_W-1:0] want;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got = m_tdata;
			if (calibrated_due.size() == 0) begin
				$error("result item %h arrived with no sample waiting", got);
				failures++;
			end else begin
				want = calibrated_due.pop_front();
				for (f = 0; f < 6; f++) begin
					if (got[16*f +: 16] !== want[16*f +: 16]) begin
						$error("%s: expected %0d, got %0d", result_fields[f],
							$signed(want[16*f +: 16]), $signed(got[16*f +: 16]));
						failures++;
					end
				end
			end
		end
	end

	// Ends the run if no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("mag_calibrate_lowpass_test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		offsets_mirror = mcl_pkg::OFFSETS_RST;
		coef_mirror[0] = mcl_pkg::COEF_X_RST;
		coef_mirror[1] = mcl_pkg::COEF_Y_RST;
		coef_mirror[2] = mcl_pkg::COEF_Z_RST;
		gain_mirror = mcl_pkg::GAIN_ONE;
		smooth_mirror[0] = '0;
		smooth_mirror[1] = '0;
		smooth_mirror[2] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_defaults();
		test_matrix_extremes();
		test_rounding_ties();
		test_gain_edges();
		test_unknown_slots();
		test_random_phases();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("mag_calibrate_lowpass_test passed");
		end else begin
			$display("mag_calibrate_lowpass_test failed");
		end
		$finish;
	end

endmodule
